FILE: hw/rtl/otwk_pkg.sv
// Shared types, constants and the arctangent table for the three-wheel omni kinematics block.
// Used by the cells, the top level and the checker; depends on nothing else.
package otwk_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int DIV_STEPS    = 20;
	// fold, rotation cells, seven arithmetic stages, division cells, output register
	localparam int LATENCY      = CORDIC_STEPS + DIV_STEPS + 9;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TRAVEL_SPEED = 2'd0;
	localparam reg_idx_t REG_ROBOT_RADIUS = 2'd1;
	localparam reg_idx_t REG_WHEEL_RADIUS = 2'd2;

	localparam logic [11:0] TRAVEL_SPEED_RST = 12'd800;
	localparam logic [9:0]  ROBOT_RADIUS_RST = 10'd100;
	localparam logic [7:0]  WHEEL_RADIUS_RST = 8'd29;

	localparam logic signed [15:0] FULL_TURN    = 16'sd5760;
	localparam logic signed [15:0] HALF_TURN    = 16'sd2880;
	localparam logic signed [15:0] QUARTER_TURN = 16'sd1440;

	localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
	localparam logic signed [17:0] SQRT3_Q16    = 18'sd113512;
	localparam logic [32:0]        PI_Q31       = 33'd6746518852;
	localparam logic [19:0]        POS_LIMIT    = 20'd262143;
	localparam logic [19:0]        NEG_LIMIT    = 20'd262144;
	localparam logic signed [18:0] OUT_MAX      = 19'sd262143;
	localparam logic signed [18:0] OUT_MIN      = -19'sd262144;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [23:0] z;
		logic               flip;
		logic signed [15:0] turn;
		logic [11:0]        speed;
		logic [9:0]         radius;
		logic [7:0]         wheel;
	} cordic_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [40:0] den;
		logic [19:0] quo;
		logic        neg;
		logic        ovf;
		logic        zero;
	} div_lane_t;

	// Arctangent of 2^-i in degrees times 65536.
	function automatic logic [23:0] atan_deg16(input int unsigned i);
		logic [23:0] v;
		case (i)
			0:       v = 24'd2949120;
			1:       v = 24'd1740967;
			2:       v = 24'd919879;
			3:       v = 24'd466945;
			4:       v = 24'd234379;
			5:       v = 24'd117304;
			6:       v = 24'd58666;
			7:       v = 24'd29335;
			8:       v = 24'd14668;
			9:       v = 24'd7334;
			10:      v = 24'd3667;
			11:      v = 24'd1833;
			12:      v = 24'd917;
			13:      v = 24'd458;
			14:      v = 24'd229;
			15:      v = 24'd115;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/omni_three_wheel_kinematics.sv
// Top level of the three-wheel omni inverse kinematics pipeline.
// Depends on otwk_pkg, otwk_cordic_cell and otwk_div_cell.
//
//  channel   signals                                     handshake
//  command   start, heading, turn_rate / busy            start & !busy
//  result    done, wheel_*_rpm, clipped                  done, one cycle
//  config    cfg_valid, cfg_index, cfg_data / cfg_ready  cfg_valid & cfg_ready
//
// A command may be given in every cycle; busy stays low and cfg_ready stays high.
// Each result is registered through the fold register, the sixteen rotation cells,
// seven arithmetic stages, twenty division cells and the output register.
// Reset sets the configuration registers to their defaults and drops all requests in flight.
// The receiver cannot stall, so nothing is held back.
module omni_three_wheel_kinematics (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [13:0] heading,
	input  logic signed [15:0] turn_rate,
	output logic               done,
	output logic signed [18:0] wheel_one_rpm,
	output logic signed [18:0] wheel_two_rpm,
	output logic signed [18:0] wheel_three_rpm,
	output logic               clipped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	localparam int NS = otwk_pkg::CORDIC_STEPS;
	localparam int ND = otwk_pkg::DIV_STEPS;
	localparam int LAT = otwk_pkg::LATENCY;

	logic [11:0] speed_q;
	logic [9:0]  radius_q;
	logic [7:0]  wheel_q;
	logic        acc;
	logic [LAT-1:0] vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign acc       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= otwk_pkg::TRAVEL_SPEED_RST;
			radius_q <= otwk_pkg::ROBOT_RADIUS_RST;
			wheel_q  <= otwk_pkg::WHEEL_RADIUS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				otwk_pkg::REG_TRAVEL_SPEED: speed_q  <= cfg_data;
				otwk_pkg::REG_ROBOT_RADIUS: radius_q <= cfg_data[9:0];
				otwk_pkg::REG_WHEEL_RADIUS: wheel_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end

	// Wrap the heading into one turn and fold it into the right half plane.
	logic signed [15:0] a0;
	logic signed [15:0] a1;
	logic signed [15:0] a2;
	logic signed [15:0] a3;
	logic               flip;

	always_comb begin
		a0 = 16'(heading) + 16'sd11520;
		if (a0 >= 16'sd17280) begin
			a1 = a0 - 16'sd17280;
		end else if (a0 >= 16'sd11520) begin
			a1 = a0 - 16'sd11520;
		end else if (a0 >= otwk_pkg::FULL_TURN) begin
			a1 = a0 - otwk_pkg::FULL_TURN;
		end else begin
			a1 = a0;
		end
		a2 = (a1 > otwk_pkg::HALF_TURN) ? (a1 - otwk_pkg::FULL_TURN) : a1;
		flip = 1'b0;
		a3 = a2;
		if (a2 > otwk_pkg::QUARTER_TURN) begin
			a3   = a2 - otwk_pkg::HALF_TURN;
			flip = 1'b1;
		end else if (a2 < -otwk_pkg::QUARTER_TURN) begin
			a3   = a2 + otwk_pkg::HALF_TURN;
			flip = 1'b1;
		end
	end

	otwk_pkg::cordic_t cord [NS+1];

	always_ff @(posedge clk) begin
		cord[0].x      <= otwk_pkg::CORDIC_START;
		cord[0].y      <= '0;
		cord[0].z      <= {a3[11:0], 12'd0};
		cord[0].flip   <= flip;
		cord[0].turn   <= turn_rate;
		cord[0].speed  <= speed_q;
		cord[0].radius <= radius_q;
		cord[0].wheel  <= wheel_q;
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		otwk_cordic_cell #(.STEP(i)) u_cell (
			.clk (clk),
			.d   (cord[i]),
			.q   (cord[i+1])
		);
	end

	// Post rotation: undo the fold and round to Q15.
	logic signed [32:0] xf;
	logic signed [32:0] yf;
	logic signed [32:0] xr;
	logic signed [32:0] yr;
	logic signed [17:0] cos_s17;
	logic signed [17:0] sin_s17;
	logic signed [26:0] rotp_s17;
	logic [11:0]        speed_s17;
	logic [7:0]         wheel_s17;

	assign xf = cord[NS].flip ? -cord[NS].x : cord[NS].x;
	assign yf = cord[NS].flip ? -cord[NS].y : cord[NS].y;
	assign xr = xf + 33'sd16384;
	assign yr = yf + 33'sd16384;

	always_ff @(posedge clk) begin
		cos_s17   <= xr[32:15];
		sin_s17   <= yr[32:15];
		rotp_s17  <= $signed({1'b0, cord[NS].radius}) * cord[NS].turn;
		speed_s17 <= cord[NS].speed;
		wheel_s17 <= cord[NS].wheel;
	end

	logic signed [30:0] vx_s18;
	logic signed [30:0] vy_s18;
	logic signed [26:0] rotp_s18;
	logic [40:0]        den_s18;

	always_ff @(posedge clk) begin
		vx_s18   <= $signed({1'b0, speed_s17}) * cos_s17;
		vy_s18   <= $signed({1'b0, speed_s17}) * sin_s17;
		rotp_s18 <= rotp_s17;
		den_s18  <= wheel_s17 * otwk_pkg::PI_Q31;
	end

	logic signed [48:0] sx_s19;
	logic signed [46:0] sy_s19;
	logic signed [49:0] rot_s19;
	logic [40:0]        den_s19;

	always_ff @(posedge clk) begin
		sx_s19  <= vx_s18 * otwk_pkg::SQRT3_Q16;
		sy_s19  <= {vy_s18, 16'd0};
		rot_s19 <= {rotp_s18, 23'd0};
		den_s19 <= den_s18;
	end

	logic signed [51:0] sx;
	logic signed [51:0] sy;
	logic signed [51:0] rot;
	logic signed [51:0] t_s20 [3];
	logic [40:0]        den_s20;

	assign sx  = 52'(sx_s19);
	assign sy  = 52'(sy_s19);
	assign rot = 52'(rot_s19);

	always_ff @(posedge clk) begin
		t_s20[0] <= rot - sy - sy;
		t_s20[1] <= sx + sy + rot;
		t_s20[2] <= sy + rot - sx;
		den_s20  <= den_s19;
	end

	// Scale by 160 in a 64-bit word that wraps.
	logic signed [63:0] num_s21 [3];
	logic [40:0]        den_s21;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			num_s21[j] <= (64'(t_s20[j]) <<< 7) + (64'(t_s20[j]) <<< 5);
		end
		den_s21 <= den_s20;
	end

	logic [63:0] n_s22 [3];
	logic        neg_s22 [3];
	logic        zero_s22 [3];
	logic [40:0] den_s22;

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			n_s22[j]    <= (num_s21[j][63] ? (64'd0 - 64'(num_s21[j])) : 64'(num_s21[j]))
				+ {24'd0, den_s21[40:1]};
			neg_s22[j]  <= num_s21[j][63];
			zero_s22[j] <= (num_s21[j] == 64'sd0);
		end
		den_s22 <= den_s21;
	end

	// A quotient of 2^20 or more saturates whatever its sign.
	logic [63:0]         lim;
	otwk_pkg::div_lane_t lane [3][ND+1];

	assign lim = {3'd0, den_s22, 20'd0};

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			lane[j][0].rem  <= n_s22[j];
			lane[j][0].den  <= den_s22;
			lane[j][0].quo  <= '0;
			lane[j][0].neg  <= neg_s22[j];
			lane[j][0].ovf  <= (n_s22[j] >= lim);
			lane[j][0].zero <= zero_s22[j];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_lane
		for (genvar m = 0; m < ND; m++) begin : g_div
			otwk_div_cell #(.SHIFT(ND-1-m)) u_cell (
				.clk (clk),
				.d   (lane[j][m]),
				.q   (lane[j][m+1])
			);
		end
	end

	logic signed [18:0] res [3];
	logic               sat [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			res[j] = '0;
			sat[j] = 1'b0;
			if (lane[j][ND].zero) begin
				res[j] = '0;
			end else if (lane[j][ND].ovf) begin
				sat[j] = 1'b1;
				res[j] = lane[j][ND].neg ? otwk_pkg::OUT_MIN : otwk_pkg::OUT_MAX;
			end else if (lane[j][ND].neg) begin
				if (lane[j][ND].quo > otwk_pkg::NEG_LIMIT) begin
					sat[j] = 1'b1;
					res[j] = otwk_pkg::OUT_MIN;
				end else begin
					res[j] = $signed(19'(20'd0 - lane[j][ND].quo));
				end
			end else if (lane[j][ND].quo > otwk_pkg::POS_LIMIT) begin
				sat[j] = 1'b1;
				res[j] = otwk_pkg::OUT_MAX;
			end else begin
				res[j] = $signed(lane[j][ND].quo[18:0]);
			end
		end
	end

	logic signed [18:0] w1_q;
	logic signed [18:0] w2_q;
	logic signed [18:0] w3_q;
	logic               clip_q;

	always_ff @(posedge clk) begin
		w1_q   <= res[0];
		w2_q   <= res[1];
		w3_q   <= res[2];
		clip_q <= sat[0] | sat[1] | sat[2];
	end

	assign done            = vld_q[LAT-1];
	assign wheel_one_rpm   = w1_q;
	assign wheel_two_rpm   = w2_q;
	assign wheel_three_rpm = w3_q;
	assign clipped         = clip_q;

endmodule

FILE: hw/rtl/otwk_cordic_cell.sv
// One rotation step of the sine and cosine chain, registered.
// Depends on otwk_pkg for the stage record and the arctangent table.
module otwk_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic             clk,
	input  otwk_pkg::cordic_t d,
	output otwk_pkg::cordic_t q
);

	logic signed [23:0] ang;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	otwk_pkg::cordic_t  nxt;

	assign ang = $signed(otwk_pkg::atan_deg16(STEP));
	assign dx  = d.y >>> STEP;
	assign dy  = d.x >>> STEP;

	always_comb begin
		nxt = d;
		if (d.z >= 0) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ang;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

FILE: hw/rtl/otwk_div_cell.sv
// One restoring division step for one wheel lane, registered.
// Depends on otwk_pkg for the lane record.
module otwk_div_cell #(
	parameter int unsigned SHIFT = 0
) (
	input  logic               clk,
	input  otwk_pkg::div_lane_t d,
	output otwk_pkg::div_lane_t q
);

	logic [63:0]         trial;
	otwk_pkg::div_lane_t nxt;

	assign trial = {23'd0, d.den} << SHIFT;

	always_comb begin
		nxt = d;
		if (!d.ovf && (d.rem >= trial)) begin
			nxt.rem        = d.rem - trial;
			nxt.quo[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end

endmodule

FILE: hw/rtl/otwk_checker.sv
// Port-level checks for the omni kinematics block, bound to its top level.
// Depends on otwk_pkg for the pipeline latency and the output limits.
module otwk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [18:0] wheel_one_rpm,
	input logic signed [18:0] wheel_two_rpm,
	input logic signed [18:0] wheel_three_rpm,
	input logic               clipped
);

	// Every request yields its result, delayed by the package latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(otwk_pkg::LATENCY) done)
		else $error("request without result");

	// No result without a request, the package latency earlier.
	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, otwk_pkg::LATENCY))
		else $error("result without request");

	// The flag only comes with a wheel at one of its limits.
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |->
			(wheel_one_rpm == otwk_pkg::OUT_MAX) || (wheel_one_rpm == otwk_pkg::OUT_MIN) ||
			(wheel_two_rpm == otwk_pkg::OUT_MAX) || (wheel_two_rpm == otwk_pkg::OUT_MIN) ||
			(wheel_three_rpm == otwk_pkg::OUT_MAX) ||
			(wheel_three_rpm == otwk_pkg::OUT_MIN))
		else $error("clipped without a saturated wheel");

endmodule

bind omni_three_wheel_kinematics otwk_checker u_otwk_checker (.*);
